@@ sv/asp_pkg.sv @@
package asp_pkg;

    localparam int SITE_SLOTS_DEF  = 4096;
    localparam int LIVE_SLOTS_DEF  = 16384;
    localparam int PROBE_LIMIT_DEF = 64;
    localparam int HIST_BINS_DEF   = 40;

    localparam int CNT_W      = 48;
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 40;
    localparam int KEY_W      = 64;
    localparam int IDX_W      = 12;
    localparam int SITE_IDX_W = 16;
    localparam int BIN_W      = 6;
    localparam int LIVE_SHIFT = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_READ_SITE = 2'd2,
        CMD_READ_HIST = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_UNMATCHED = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_A_HRD,
        S_A_HWR,
        S_A_SRD,
        S_A_SCHK,
        S_A_LRD,
        S_A_LCHK,
        S_F_LRD,
        S_F_LCHK,
        S_F_SRD,
        S_F_SWR,
        S_R_SRD,
        S_R_SCHK,
        S_H_RD,
        S_H_OUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] calls;
        logic [CNT_W-1:0] bytes;
        logic [CNT_W-1:0] now;
        logic [CNT_W-1:0] peak;
    } site_ent_t;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_W-1:0]     addr;
        logic [SIZE_W-1:0]     size;
        logic [SITE_IDX_W-1:0] site;
    } live_ent_t;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    site_rd;
        logic    site_adv;
        logic    site_wr_alloc;
        logic    site_wr_free;
        logic    live_rd;
        logic    live_adv;
        logic    live_wr_alloc;
        logic    live_wr_free;
        logic    hist_rd;
        logic    hist_wr;
        logic    res_site;
        logic    res_hist;
        logic    set_status;
        status_t status;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t command;
        logic      addr_null;
        logic      site_oob;
        logic      hist_oob;
        logic      site_hit;
        logic      site_empty;
        logic      site_last;
        logic      live_free;
        logic      live_match;
        logic      live_last;
        logic      clr_last;
    } dp_sts_t;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sub_floor(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        return (b < a) ? (a - b) : '0;
    endfunction

    function automatic logic [BIN_W-1:0] floor_log2(logic [SIZE_W-1:0] v);
        logic [BIN_W-1:0] r;
        r = '0;
        for (int i = 1; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                r = BIN_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/asp_if.sv @@
interface asp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [47:0] address;
    logic [39:0] size;
    logic [63:0] site_key;
    logic [11:0] read_index;

    modport source (output valid, command, address, size, site_key, read_index, input ready);
    modport sink (input valid, command, address, size, site_key, read_index, output ready);
endinterface

interface asp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] site_slot;
    logic [63:0] entry_key;
    logic [47:0] site_call_count;
    logic [47:0] site_byte_count;
    logic [47:0] site_peak_live;
    logic [47:0] hist_count;
    logic [47:0] live_total;
    logic [47:0] peak_total;
    logic [47:0] alloc_total;
    logic [47:0] byte_total;
    logic [47:0] free_total;

    modport source (output valid, status, site_slot, entry_key, site_call_count,
                    site_byte_count, site_peak_live, hist_count, live_total, peak_total,
                    alloc_total, byte_total, free_total, input ready);
    modport sink (input valid, status, site_slot, entry_key, site_call_count,
                  site_byte_count, site_peak_live, hist_count, live_total, peak_total,
                  alloc_total, byte_total, free_total, output ready);
endinterface

@@ sv/asp_dp.sv @@
module asp_dp #(
    parameter int SITE_SLOTS  = asp_pkg::SITE_SLOTS_DEF,
    parameter int LIVE_SLOTS  = asp_pkg::LIVE_SLOTS_DEF,
    parameter int PROBE_LIMIT = asp_pkg::PROBE_LIMIT_DEF,
    parameter int HIST_BINS   = asp_pkg::HIST_BINS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  asp_pkg::ctrl_cmd_t  cmd,
    output asp_pkg::dp_sts_t    sts,
    input  logic [1:0]          command,
    input  logic [47:0]         address,
    input  logic [39:0]         size,
    input  logic [63:0]         site_key,
    input  logic [11:0]         read_index,
    output logic [1:0]          status,
    output logic [11:0]         site_slot,
    output logic [63:0]         entry_key,
    output logic [47:0]         site_call_count,
    output logic [47:0]         site_byte_count,
    output logic [47:0]         site_peak_live,
    output logic [47:0]         hist_count,
    output logic [47:0]         live_total,
    output logic [47:0]         peak_total,
    output logic [47:0]         alloc_total,
    output logic [47:0]         byte_total,
    output logic [47:0]         free_total
);

    localparam int SW    = $clog2(SITE_SLOTS);
    localparam int LW    = $clog2(LIVE_SLOTS);
    localparam int HW    = $clog2(HIST_BINS);
    localparam int PW    = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int CLR_A = (SITE_SLOTS > LIVE_SLOTS) ? SITE_SLOTS : LIVE_SLOTS;
    localparam int CLR_N = (CLR_A > HIST_BINS) ? CLR_A : HIST_BINS;
    localparam int CW    = $clog2(CLR_N);

    // latched transaction
    asp_pkg::cmd_code_t cmd_reg;
    logic [47:0]        addr_reg;
    logic [39:0]        size_reg;
    logic [63:0]        key_reg;
    logic [11:0]        ridx_reg;

    logic [SW-1:0] site_ptr_reg;
    logic [SW-1:0] site_cnt_reg;
    logic [LW-1:0] live_ptr_reg;
    logic [PW-1:0] live_cnt_reg;
    logic [HW-1:0] hist_ptr_reg;
    logic [CW-1:0] clr_reg;

    asp_pkg::site_ent_t site_q_reg;
    asp_pkg::live_ent_t live_q_reg;
    logic [47:0]        hist_q_reg;

    asp_pkg::status_t res_status_reg;
    logic [11:0]      res_slot_reg;
    logic [63:0]      res_key_reg;
    logic [47:0]      res_calls_reg;
    logic [47:0]      res_bytes_reg;
    logic [47:0]      res_peak_reg;
    logic [47:0]      res_hist_reg;

    logic [47:0] allocs_reg;
    logic [47:0] bytes_reg;
    logic [47:0] frees_reg;
    logic [47:0] live_reg;
    logic [47:0] peak_reg;

    logic [1:0]  out_status_reg;
    logic [11:0] out_slot_reg;
    logic [63:0] out_key_reg;
    logic [47:0] out_calls_reg;
    logic [47:0] out_bytes_reg;
    logic [47:0] out_peak_reg;
    logic [47:0] out_hist_reg;
    logic [47:0] out_live_reg;
    logic [47:0] out_ptot_reg;
    logic [47:0] out_allocs_reg;
    logic [47:0] out_btot_reg;
    logic [47:0] out_frees_reg;

    asp_pkg::site_ent_t site_mem [SITE_SLOTS];
    asp_pkg::live_ent_t live_mem [LIVE_SLOTS];
    logic [47:0]        hist_mem [HIST_BINS];

    logic [63:0]             key_eff;
    logic [asp_pkg::BIN_W-1:0] lg;
    logic [HW-1:0]           bin;
    logic [47:0]             live_next;
    asp_pkg::site_ent_t      site_alloc_ent;
    asp_pkg::site_ent_t      site_free_ent;
    logic [47:0]             now_new;
    logic [47:0]             hist_inc;

    logic               site_we;
    logic [SW-1:0]      site_wa;
    asp_pkg::site_ent_t site_wd;
    logic               live_we;
    logic [LW-1:0]      live_wa;
    asp_pkg::live_ent_t live_wd;
    logic               hist_we;
    logic [HW-1:0]      hist_wa;
    logic [47:0]        hist_wd;

    assign key_eff   = (site_key == '0) ? 64'd1 : site_key;
    assign lg        = asp_pkg::floor_log2(size);
    assign bin       = (int'(lg) > HIST_BINS - 1) ? HW'(HIST_BINS - 1) : HW'(lg);
    assign live_next = asp_pkg::sat_add(live_reg, 48'(size));
    assign hist_inc  = asp_pkg::sat_add(hist_q_reg, 48'd1);

    always_comb
    begin
        now_new             = asp_pkg::sat_add(site_q_reg.now, 48'(size_reg));
        site_alloc_ent.key   = key_reg;
        site_alloc_ent.calls = asp_pkg::sat_add(site_q_reg.calls, 48'd1);
        site_alloc_ent.bytes = asp_pkg::sat_add(site_q_reg.bytes, 48'(size_reg));
        site_alloc_ent.now   = now_new;
        site_alloc_ent.peak  = (now_new > site_q_reg.peak) ? now_new : site_q_reg.peak;
        site_free_ent        = site_q_reg;
        site_free_ent.now    = asp_pkg::sub_floor(site_q_reg.now, 48'(size_reg));
    end

    always_comb
    begin
        sts.command    = cmd_reg;
        sts.addr_null  = (addr_reg == '0);
        sts.site_oob   = (int'(ridx_reg) >= SITE_SLOTS);
        sts.hist_oob   = (int'(ridx_reg) >= HIST_BINS);
        sts.site_empty = (site_q_reg.key == '0);
        sts.site_hit   = (site_q_reg.key == '0) || (site_q_reg.key == key_reg);
        sts.site_last  = (site_cnt_reg == SW'(SITE_SLOTS - 1));
        sts.live_free  = !live_q_reg.valid;
        sts.live_match = live_q_reg.valid && (live_q_reg.addr == addr_reg);
        sts.live_last  = (live_cnt_reg == PW'(PROBE_LIMIT - 1));
        sts.clr_last   = (clr_reg == CW'(CLR_N - 1));
    end

    // write port selection, clearing pass takes priority
    always_comb
    begin
        site_we = 1'b0;
        site_wa = site_ptr_reg;
        site_wd = site_alloc_ent;
        if (cmd.clr)
        begin
            site_we = (int'(clr_reg) < SITE_SLOTS);
            site_wa = clr_reg[SW-1:0];
            site_wd = '0;
        end
        else if (cmd.site_wr_alloc)
        begin
            site_we = 1'b1;
        end
        else if (cmd.site_wr_free)
        begin
            site_we = 1'b1;
            site_wd = site_free_ent;
        end
    end

    always_comb
    begin
        live_we       = 1'b0;
        live_wa       = live_ptr_reg;
        live_wd.valid = 1'b1;
        live_wd.addr  = addr_reg;
        live_wd.size  = size_reg;
        live_wd.site  = asp_pkg::SITE_IDX_W'(site_ptr_reg);
        if (cmd.clr)
        begin
            live_we = (int'(clr_reg) < LIVE_SLOTS);
            live_wa = clr_reg[LW-1:0];
            live_wd = '0;
        end
        else if (cmd.live_wr_alloc)
        begin
            live_we = 1'b1;
        end
        else if (cmd.live_wr_free)
        begin
            live_we = 1'b1;
            live_wd = '0;
        end
    end

    always_comb
    begin
        hist_we = 1'b0;
        hist_wa = hist_ptr_reg;
        hist_wd = hist_inc;
        if (cmd.clr)
        begin
            hist_we = (int'(clr_reg) < HIST_BINS);
            hist_wa = clr_reg[HW-1:0];
            hist_wd = '0;
        end
        else if (cmd.hist_wr)
        begin
            hist_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (site_we)
        begin
            site_mem[site_wa] <= site_wd;
        end
        if (cmd.site_rd)
        begin
            site_q_reg <= site_mem[site_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_wa] <= live_wd;
        end
        if (cmd.live_rd)
        begin
            live_q_reg <= live_mem[live_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (cmd.hist_rd)
        begin
            hist_q_reg <= hist_mem[hist_ptr_reg];
        end
    end

    // probe pointers and latched fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= asp_pkg::cmd_code_t'(command);
            addr_reg     <= address;
            size_reg     <= size;
            key_reg      <= key_eff;
            ridx_reg     <= read_index;
            site_ptr_reg <= (command == asp_pkg::CMD_READ_SITE) ? SW'(read_index)
                                                                : key_eff[SW-1:0];
            site_cnt_reg <= '0;
            live_ptr_reg <= address[asp_pkg::LIVE_SHIFT +: LW];
            live_cnt_reg <= '0;
            hist_ptr_reg <= (command == asp_pkg::CMD_READ_HIST) ? HW'(read_index) : bin;
        end
        else
        begin
            if (cmd.site_adv)
            begin
                site_ptr_reg <= site_ptr_reg + 1'b1;
                site_cnt_reg <= site_cnt_reg + 1'b1;
            end
            if (cmd.live_adv)
            begin
                live_ptr_reg <= live_ptr_reg + 1'b1;
                live_cnt_reg <= live_cnt_reg + 1'b1;
            end
            if (cmd.live_wr_free)
            begin
                size_reg     <= live_q_reg.size;
                site_ptr_reg <= SW'(live_q_reg.site);
            end
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_status_reg <= asp_pkg::STAT_OK;
            res_slot_reg   <= (command == asp_pkg::CMD_READ_SITE) ? read_index : '0;
            res_key_reg    <= '0;
            res_calls_reg  <= '0;
            res_bytes_reg  <= '0;
            res_peak_reg   <= '0;
            res_hist_reg   <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status;
            end
            if (cmd.site_wr_alloc)
            begin
                res_slot_reg  <= 12'(site_ptr_reg);
                res_key_reg   <= site_alloc_ent.key;
                res_calls_reg <= site_alloc_ent.calls;
                res_bytes_reg <= site_alloc_ent.bytes;
                res_peak_reg  <= site_alloc_ent.peak;
            end
            if (cmd.site_wr_free || cmd.res_site)
            begin
                res_slot_reg  <= 12'(site_ptr_reg);
                res_key_reg   <= site_q_reg.key;
                res_calls_reg <= site_q_reg.calls;
                res_bytes_reg <= site_q_reg.bytes;
                res_peak_reg  <= site_q_reg.peak;
            end
            if (cmd.hist_wr)
            begin
                res_hist_reg <= hist_inc;
            end
            if (cmd.res_hist)
            begin
                res_hist_reg <= hist_q_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allocs_reg <= '0;
            bytes_reg  <= '0;
            frees_reg  <= '0;
            live_reg   <= '0;
            peak_reg   <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load && command == asp_pkg::CMD_ALLOC)
            begin
                allocs_reg <= asp_pkg::sat_add(allocs_reg, 48'd1);
                bytes_reg  <= asp_pkg::sat_add(bytes_reg, 48'(size));
                live_reg   <= live_next;
                if (live_next > peak_reg)
                begin
                    peak_reg <= live_next;
                end
            end
            if (cmd.load && command == asp_pkg::CMD_FREE && address != '0)
            begin
                frees_reg <= asp_pkg::sat_add(frees_reg, 48'd1);
            end
            if (cmd.live_wr_free)
            begin
                live_reg <= asp_pkg::sub_floor(live_reg, 48'(live_q_reg.size));
            end
        end
    end

    // output register, holds until taken
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_key_reg    <= res_key_reg;
            out_calls_reg  <= res_calls_reg;
            out_bytes_reg  <= res_bytes_reg;
            out_peak_reg   <= res_peak_reg;
            out_hist_reg   <= res_hist_reg;
            out_live_reg   <= live_reg;
            out_ptot_reg   <= peak_reg;
            out_allocs_reg <= allocs_reg;
            out_btot_reg   <= bytes_reg;
            out_frees_reg  <= frees_reg;
        end
    end

    assign status          = out_status_reg;
    assign site_slot       = out_slot_reg;
    assign entry_key       = out_key_reg;
    assign site_call_count = out_calls_reg;
    assign site_byte_count = out_bytes_reg;
    assign site_peak_live  = out_peak_reg;
    assign hist_count      = out_hist_reg;
    assign live_total      = out_live_reg;
    assign peak_total      = out_ptot_reg;
    assign alloc_total     = out_allocs_reg;
    assign byte_total      = out_btot_reg;
    assign free_total      = out_frees_reg;

endmodule

@@ sv/asp_ctrl.sv @@
module asp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  asp_pkg::dp_sts_t   sts,
    output asp_pkg::ctrl_cmd_t cmd
);

    asp_pkg::state_t state_reg;
    asp_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign ready     = (state_reg == asp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asp_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = asp_pkg::S_IDLE;
                end
            end
            asp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = asp_pkg::S_DISP;
                end
            end
            asp_pkg::S_DISP:
            begin
                unique case (sts.command)
                    asp_pkg::CMD_ALLOC:     state_next = asp_pkg::S_A_HRD;
                    asp_pkg::CMD_FREE:      state_next = sts.addr_null ? asp_pkg::S_DONE
                                                                       : asp_pkg::S_F_LRD;
                    asp_pkg::CMD_READ_SITE: state_next = sts.site_oob ? asp_pkg::S_DONE
                                                                      : asp_pkg::S_R_SRD;
                    default:                state_next = sts.hist_oob ? asp_pkg::S_DONE
                                                                      : asp_pkg::S_H_RD;
                endcase
            end
            asp_pkg::S_A_HRD:  state_next = asp_pkg::S_A_HWR;
            asp_pkg::S_A_HWR:  state_next = asp_pkg::S_A_SRD;
            asp_pkg::S_A_SRD:  state_next = asp_pkg::S_A_SCHK;
            asp_pkg::S_A_SCHK:
            begin
                if (sts.site_hit)
                begin
                    state_next = sts.addr_null ? asp_pkg::S_DONE : asp_pkg::S_A_LRD;
                end
                else if (sts.site_last)
                begin
                    state_next = asp_pkg::S_DONE;
                end
                else
                begin
                    state_next = asp_pkg::S_A_SRD;
                end
            end
            asp_pkg::S_A_LRD:  state_next = asp_pkg::S_A_LCHK;
            asp_pkg::S_A_LCHK:
            begin
                state_next = (sts.live_free || sts.live_last) ? asp_pkg::S_DONE
                                                              : asp_pkg::S_A_LRD;
            end
            asp_pkg::S_F_LRD:  state_next = asp_pkg::S_F_LCHK;
            asp_pkg::S_F_LCHK:
            begin
                if (sts.live_match)
                begin
                    state_next = asp_pkg::S_F_SRD;
                end
                else if (sts.live_last)
                begin
                    state_next = asp_pkg::S_DONE;
                end
                else
                begin
                    state_next = asp_pkg::S_F_LRD;
                end
            end
            asp_pkg::S_F_SRD:  state_next = asp_pkg::S_F_SWR;
            asp_pkg::S_F_SWR:  state_next = asp_pkg::S_DONE;
            asp_pkg::S_R_SRD:  state_next = asp_pkg::S_R_SCHK;
            asp_pkg::S_R_SCHK: state_next = asp_pkg::S_DONE;
            asp_pkg::S_H_RD:   state_next = asp_pkg::S_H_OUT;
            asp_pkg::S_H_OUT:  state_next = asp_pkg::S_DONE;
            asp_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = asp_pkg::S_IDLE;
                end
            end
            default:           state_next = asp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.status = asp_pkg::STAT_OK;
        cmd.load   = in_valid && ready;
        unique case (state_reg)
            asp_pkg::S_CLEAR: cmd.clr = 1'b1;
            asp_pkg::S_DISP:
            begin
                if ((sts.command == asp_pkg::CMD_READ_SITE && sts.site_oob)
                    || (sts.command == asp_pkg::CMD_READ_HIST && sts.hist_oob))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = asp_pkg::STAT_EMPTY;
                end
            end
            asp_pkg::S_A_HRD: cmd.hist_rd = 1'b1;
            asp_pkg::S_A_HWR: cmd.hist_wr = 1'b1;
            asp_pkg::S_A_SRD: cmd.site_rd = 1'b1;
            asp_pkg::S_A_SCHK:
            begin
                if (sts.site_hit)
                begin
                    cmd.site_wr_alloc = 1'b1;
                end
                else if (sts.site_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = asp_pkg::STAT_FULL;
                end
                else
                begin
                    cmd.site_adv = 1'b1;
                end
            end
            asp_pkg::S_A_LRD: cmd.live_rd = 1'b1;
            asp_pkg::S_A_LCHK:
            begin
                if (sts.live_free)
                begin
                    cmd.live_wr_alloc = 1'b1;
                end
                else if (!sts.live_last)
                begin
                    cmd.live_adv = 1'b1;
                end
            end
            asp_pkg::S_F_LRD: cmd.live_rd = 1'b1;
            asp_pkg::S_F_LCHK:
            begin
                if (sts.live_match)
                begin
                    cmd.live_wr_free = 1'b1;
                end
                else if (sts.live_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = asp_pkg::STAT_UNMATCHED;
                end
                else
                begin
                    cmd.live_adv = 1'b1;
                end
            end
            asp_pkg::S_F_SRD: cmd.site_rd      = 1'b1;
            asp_pkg::S_F_SWR: cmd.site_wr_free = 1'b1;
            asp_pkg::S_R_SRD: cmd.site_rd      = 1'b1;
            asp_pkg::S_R_SCHK:
            begin
                if (sts.site_empty)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = asp_pkg::STAT_EMPTY;
                end
                else
                begin
                    cmd.res_site = 1'b1;
                end
            end
            asp_pkg::S_H_RD:  cmd.hist_rd  = 1'b1;
            asp_pkg::S_H_OUT: cmd.res_hist = 1'b1;
            asp_pkg::S_DONE:  cmd.out_load = out_free;
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asp_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/allocation_site_profiler.sv @@
// allocation site profiler: takes alloc, free and read transactions on req and returns
// one result per transaction on rsp. after reset the site table, live map and histogram
// are swept clear, one entry a cycle over max(SITE_SLOTS, LIVE_SLOTS, HIST_BINS) entries
// (16384 by default), and req.ready stays low meanwhile. one transaction is worked at
// a time, bounded by the single-port site and live memories where each probe is a read
// followed by a check: an alloc bumps its histogram bin and probes the site table, then
// the live map; a free probes the live map, then updates its site entry. the next
// transaction is taken while a finished result waits on rsp.
module allocation_site_profiler #(
    parameter int SITE_SLOTS  = asp_pkg::SITE_SLOTS_DEF,
    parameter int LIVE_SLOTS  = asp_pkg::LIVE_SLOTS_DEF,
    parameter int PROBE_LIMIT = asp_pkg::PROBE_LIMIT_DEF,
    parameter int HIST_BINS   = asp_pkg::HIST_BINS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    asp_in_if.sink    req,
    asp_out_if.source rsp
);

    asp_pkg::ctrl_cmd_t cmd;
    asp_pkg::dp_sts_t   sts;
    logic               ready;
    logic               out_valid;

    asp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .ready     (ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    asp_dp #(
        .SITE_SLOTS  (SITE_SLOTS),
        .LIVE_SLOTS  (LIVE_SLOTS),
        .PROBE_LIMIT (PROBE_LIMIT),
        .HIST_BINS   (HIST_BINS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .command         (req.command),
        .address         (req.address),
        .size            (req.size),
        .site_key        (req.site_key),
        .read_index      (req.read_index),
        .status          (rsp.status),
        .site_slot       (rsp.site_slot),
        .entry_key       (rsp.entry_key),
        .site_call_count (rsp.site_call_count),
        .site_byte_count (rsp.site_byte_count),
        .site_peak_live  (rsp.site_peak_live),
        .hist_count      (rsp.hist_count),
        .live_total      (rsp.live_total),
        .peak_total      (rsp.peak_total),
        .alloc_total     (rsp.alloc_total),
        .byte_total      (rsp.byte_total),
        .free_total      (rsp.free_total)
    );

    assign req.ready = ready;
    assign rsp.valid = out_valid;

    a_peak_covers_live: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.peak_total >= rsp.live_total)
        else $error("peak total below live total");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("transaction taken while another is in work");

    a_full_no_site: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == 2'(asp_pkg::STAT_FULL))
        |-> (rsp.site_slot == '0 && rsp.entry_key == '0))
        else $error("site fields set on full site table");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !req.ready)
        else $error("transaction taken during clearing pass");

endmodule
